FILE: src/hit_label_aggregation_table_defines.svh
// Assertion helpers for the block's top-level RTL file.
`ifndef HIT_LABEL_AGGREGATION_TABLE_DEFINES_SVH
`define HIT_LABEL_AGGREGATION_TABLE_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define HLAT_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define HLAT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/hlat_pkg.sv
`default_nettype none

package hlat_pkg;

   localparam int ENTRIES   = 64;
   localparam int DISKS     = 5;
   localparam int LABEL_W   = 64;
   localparam int COUNT_W   = 8;
   localparam int LAYER_W   = 4;
   localparam int DISK_W    = LAYER_W - 1;
   localparam int CROSSED_W = 3;
   localparam int MIN_W     = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [MIN_W-1:0]   MIN_DISKS_RESET = MIN_W'(4);

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic [LABEL_W-1:0]   label;
      logic [COUNT_W-1:0]   count;
      logic [DISKS-1:0]     mask;
   } entry_type;

   typedef struct packed {
      logic                 add_en;
      logic                 shift_en;
      logic                 any_match;
      logic [LABEL_W-1:0]   label;
      logic [DISKS-1:0]     hit_mask;
   } cell_ctrl_type;

   typedef struct packed {
      logic [LABEL_W-1:0]   entry_label;
      logic [COUNT_W-1:0]   hit_count;
      logic [DISKS-1:0]     disk_mask;
      logic [CROSSED_W-1:0] crossed_disks;
      logic                 trackable;
      logic                 entry_valid;
      logic                 overflow;
      logic                 last;
   } result_type;

endpackage

`default_nettype wire

FILE: src/hlat_channels.sv
`default_nettype none

interface hlat_req_if import hlat_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               op;
   logic [LABEL_W-1:0] hit_label;
   logic [LAYER_W-1:0] layer;

   modport source (output valid, output op, output hit_label, output layer, input ready);
   modport sink   (input valid, input op, input hit_label, input layer, output ready);
endinterface

interface hlat_rsp_if import hlat_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [LABEL_W-1:0]   entry_label;
   logic [COUNT_W-1:0]   hit_count;
   logic [DISKS-1:0]     disk_mask;
   logic [CROSSED_W-1:0] crossed_disks;
   logic                 trackable;
   logic                 entry_valid;
   logic                 overflow;
   logic                 last;

   modport source (output valid, output entry_label, output hit_count, output disk_mask,
                   output crossed_disks, output trackable, output entry_valid,
                   output overflow, output last, input ready);
   modport sink   (input valid, input entry_label, input hit_count, input disk_mask,
                   input crossed_disks, input trackable, input entry_valid,
                   input overflow, input last, output ready);
endinterface

`default_nettype wire

FILE: src/hit_label_aggregation_table.sv
// Add: the request is accepted in IDLE, then ADD compares and updates all cells together.
// Drain: one result per stored entry, one per cycle while the sink is ready; the first
// result passes the state register and then the output register. An empty table gives one result.
// No new request is taken while the shared compare or the shift-out of the cell chain runs.
// Reset (synchronous): table empty, overflow clear, min_disks 4, output register empty.
`default_nettype none

`include "hit_label_aggregation_table_defines.svh"

module hit_label_aggregation_table
   import hlat_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   hlat_req_if.sink              req_chan,
   hlat_rsp_if.source            rsp_chan,
   input  wire logic             csr_we,
   input  wire logic [MIN_W-1:0] csr_wdata
);

   state_type          state_ff, state_in;
   logic [MIN_W-1:0]   min_disks_ff, min_disks_in;
   logic               overflow_ff, overflow_in;
   logic [LABEL_W-1:0] bcast_label_ff, bcast_label_in;
   logic [DISKS-1:0]   bcast_mask_ff, bcast_mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   entry_type          entries [ENTRIES];
   logic [ENTRIES-1:0] match_vec;
   logic [ENTRIES-1:0] valid_vec;
   cell_ctrl_type      ctrl;

   logic               accept;
   logic               add_en;
   logic               load;
   logic               last_flag;
   logic               any_match;
   logic [DISK_W-1:0]  disk;
   logic [DISKS-1:0]   hit_mask;
   logic [CROSSED_W-1:0] crossed;

   assign accept    = req_chan.valid && req_chan.ready;
   assign any_match = |match_vec;
   assign last_flag = !entries[0].valid || !entries[1].valid;

   // Disk select for the incoming hit; out-of-range disks set no bit
   always_comb begin
      disk     = req_chan.layer[LAYER_W-1:1];
      hit_mask = '0;
      for (int d = 0; d < DISKS; d++) begin
         if (disk == DISK_W'(d)) begin
            hit_mask[d] = 1'b1;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_chan.op == OP_DRAIN) ? ST_DRAIN : ST_ADD;
            end
         end
         ST_ADD: begin
            state_in = ST_IDLE;
         end
         ST_DRAIN: begin
            if (load && last_flag) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_chan.ready = 1'b0;
      add_en         = 1'b0;
      load           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_ADD: begin
            add_en = 1'b1;
         end
         ST_DRAIN: begin
            load = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   assign ctrl.add_en    = add_en;
   assign ctrl.shift_en  = load && entries[0].valid;
   assign ctrl.any_match = any_match;
   assign ctrl.label     = bcast_label_ff;
   assign ctrl.hit_mask  = bcast_mask_ff;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      hlat_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_valid ((i == 0) ? 1'b1 : entries[(i == 0) ? 0 : i-1].valid),
         .next_entry ((i == ENTRIES-1) ? entry_type'('0)
                                       : entries[(i == ENTRIES-1) ? i : i+1]),
         .entry      (entries[i]),
         .match      (match_vec[i])
      );
      assign valid_vec[i] = entries[i].valid;
   end

   always_comb begin
      crossed = '0;
      for (int d = 0; d < DISKS; d++) begin
         crossed = crossed + CROSSED_W'(entries[0].mask[d]);
      end
   end

   always_comb begin
      min_disks_in   = csr_we ? csr_wdata : min_disks_ff;
      bcast_label_in = accept ? req_chan.hit_label : bcast_label_ff;
      bcast_mask_in  = accept ? hit_mask : bcast_mask_ff;

      overflow_in = overflow_ff;
      if (add_en && !any_match && valid_vec[ENTRIES-1]) begin
         overflow_in = 1'b1;
      end else if (load && last_flag) begin
         overflow_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (entries[0].valid) begin
            rsp_data_in.entry_label   = entries[0].label;
            rsp_data_in.hit_count     = entries[0].count;
            rsp_data_in.disk_mask     = entries[0].mask;
            rsp_data_in.crossed_disks = crossed;
            rsp_data_in.trackable     = (crossed >= min_disks_ff);
            rsp_data_in.entry_valid   = 1'b1;
         end else begin
            // empty table: report one invalid result
            rsp_data_in.entry_label   = '0;
            rsp_data_in.hit_count     = '0;
            rsp_data_in.disk_mask     = '0;
            rsp_data_in.crossed_disks = '0;
            rsp_data_in.trackable     = 1'b0;
            rsp_data_in.entry_valid   = 1'b0;
         end
         rsp_data_in.overflow = overflow_ff;
         rsp_data_in.last     = last_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_disks_ff <= MIN_DISKS_RESET;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_disks_ff <= min_disks_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bcast_label_ff <= bcast_label_in;
      bcast_mask_ff  <= bcast_mask_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.entry_label   = rsp_data_ff.entry_label;
   assign rsp_chan.hit_count     = rsp_data_ff.hit_count;
   assign rsp_chan.disk_mask     = rsp_data_ff.disk_mask;
   assign rsp_chan.crossed_disks = rsp_data_ff.crossed_disks;
   assign rsp_chan.trackable     = rsp_data_ff.trackable;
   assign rsp_chan.entry_valid   = rsp_data_ff.entry_valid;
   assign rsp_chan.overflow      = rsp_data_ff.overflow;
   assign rsp_chan.last          = rsp_data_ff.last;

   `HLAT_ASSERT_NOW(a_single_match, clock, reset, 1'b1, $onehot0(match_vec),
      "more than one cell matched the label")
   `HLAT_ASSERT_NOW(a_packed_cells, clock, reset, 1'b1,
      $onehot({1'b0, valid_vec} + {{ENTRIES{1'b0}}, 1'b1}),
      "occupied cells are not packed from the head")
   `HLAT_ASSERT_NOW(a_overflow_full, clock, reset, $rose(overflow_ff),
      valid_vec[ENTRIES-1], "overflow raised while the table had room")
   `HLAT_ASSERT_NEXT(a_drain_end, clock, reset, load && last_flag,
      state_ff == ST_IDLE && valid_vec == '0, "drain ended with entries left")

endmodule

`default_nettype wire

FILE: src/hlat_cell.sv
`default_nettype none

module hlat_cell
   import hlat_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          prev_valid,
   input  wire entry_type     next_entry,
   output      entry_type     entry,
   output      logic          match
);

   logic               valid_ff, valid_in;
   logic [LABEL_W-1:0] label_ff, label_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DISKS-1:0]   mask_ff, mask_in;

   assign match = valid_ff && (label_ff == ctrl.label);

   always_comb begin
      valid_in = valid_ff;
      label_in = label_ff;
      count_in = count_ff;
      mask_in  = mask_ff;
      if (ctrl.shift_en) begin
         // advance toward the head of the chain
         valid_in = next_entry.valid;
         label_in = next_entry.label;
         count_in = next_entry.count;
         mask_in  = next_entry.mask;
      end else if (ctrl.add_en) begin
         if (match) begin
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
            mask_in = mask_ff | ctrl.hit_mask;
         end else if (!valid_ff && prev_valid && !ctrl.any_match) begin
            // first free cell takes the new label
            valid_in = 1'b1;
            label_in = ctrl.label;
            count_in = COUNT_W'(1);
            mask_in  = ctrl.hit_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      label_ff <= label_in;
      count_ff <= count_in;
      mask_ff  <= mask_in;
   end

   assign entry.valid = valid_ff;
   assign entry.label = label_ff;
   assign entry.count = count_ff;
   assign entry.mask  = mask_ff;

endmodule

`default_nettype wire

FILE: tb/sv/hlat_table_checker.sv
`default_nettype none

module hlat_table_checker
   import hlat_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   hlat_req_if                   req_chan,
   hlat_rsp_if                   rsp_chan,
   input  wire logic             csr_we,
   input  wire logic [MIN_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [LABEL_W-1:0] table_label [ENTRIES];
   logic [COUNT_W-1:0] table_count [ENTRIES];
   logic [DISKS-1:0]   table_mask  [ENTRIES];
   int                 used_entries;
   logic               hits_dropped;
   logic [MIN_W-1:0]   min_disks;
   result_type         drain_results_q [$];

   function automatic result_type table_result(logic [LABEL_W-1:0] label,
                                               logic [COUNT_W-1:0] count,
                                               logic [DISKS-1:0]   mask,
                                               logic               valid,
                                               logic               last);
      result_type r;
      int         crossed;
      int         d;
      crossed = 0;
      for (d = 0; d < DISKS; d++) begin
         crossed += int'(mask[d]);
      end
      if (!valid) begin
         crossed = 0;
      end
      r.entry_label   = label;
      r.hit_count     = count;
      r.disk_mask     = mask;
      r.crossed_disks = CROSSED_W'(crossed);
      r.trackable     = valid && (crossed >= int'(min_disks));
      r.entry_valid   = valid;
      r.overflow      = hits_dropped;
      r.last          = last;
      return r;
   endfunction

   task automatic check_field(string field, logic [LABEL_W-1:0] expected,
                              logic [LABEL_W-1:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : track
      result_type        want;
      logic [DISK_W-1:0] disk;
      logic [DISKS-1:0]  hit_bit;
      logic              found;
      if (reset) begin
         used_entries = 0;
         hits_dropped = 1'b0;
         min_disks    = MIN_DISKS_RESET;
         fail_count   = 0;
         drain_results_q.delete();
      end else begin
         if (csr_we) begin
            min_disks = csr_wdata;
         end

         if (rsp_chan.valid && rsp_chan.ready) begin
            if (drain_results_q.size() == 0) begin
               $error("unexpected result transaction: entry_label 0x%0h",
                      rsp_chan.entry_label);
               fail_count++;
            end else begin
               want = drain_results_q.pop_front();
               check_field("entry_label", want.entry_label, rsp_chan.entry_label);
               check_field("hit_count", want.hit_count, rsp_chan.hit_count);
               check_field("disk_mask", want.disk_mask, rsp_chan.disk_mask);
               check_field("crossed_disks", want.crossed_disks, rsp_chan.crossed_disks);
               check_field("trackable", want.trackable, rsp_chan.trackable);
               check_field("entry_valid", want.entry_valid, rsp_chan.entry_valid);
               check_field("overflow", want.overflow, rsp_chan.overflow);
               check_field("last", want.last, rsp_chan.last);
            end
         end

         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.op == OP_ADD) begin
               disk    = req_chan.layer[LAYER_W-1:1];
               // layers past the last disk still count but set no mask bit
               hit_bit = (int'(disk) < DISKS) ? (DISKS'(1) << disk) : '0;
               found   = 1'b0;
               for (int i = 0; i < used_entries; i++) begin
                  if (!found && table_label[i] == req_chan.hit_label) begin
                     found = 1'b1;
                     if (table_count[i] != COUNT_MAX) begin
                        table_count[i]++;
                     end
                     table_mask[i] |= hit_bit;
                  end
               end
               if (!found) begin
                  if (used_entries < ENTRIES) begin
                     table_label[used_entries] = req_chan.hit_label;
                     table_count[used_entries] = COUNT_W'(1);
                     table_mask[used_entries]  = hit_bit;
                     used_entries++;
                  end else begin
                     hits_dropped = 1'b1;
                  end
               end
            end else begin
               if (used_entries == 0) begin
                  drain_results_q.insert(drain_results_q.size(),
                                         table_result('0, '0, '0, 1'b0, 1'b1));
               end else begin
                  for (int i = 0; i < used_entries; i++) begin
                     drain_results_q.insert(drain_results_q.size(),
                                            table_result(table_label[i], table_count[i],
                                                         table_mask[i], 1'b1,
                                                         i == used_entries - 1));
                  end
               end
               used_entries = 0;
               hits_dropped = 1'b0;
            end
         end
      end
      pending_results <= drain_results_q.size();
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
   import hlat_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 12;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES = 20;
   localparam int RANDOM_ITEMS = 220;
   localparam int QUIET_ITEMS = 40;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int CYCLE_LIMIT = 200000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we;
   logic [MIN_W-1:0] csr_wdata;
   int               fail_count;
   int               pending_results;
   int               items_sent = 0;
   int               cycle_count = 0;
   int               hold_off_len = 0;
   bit               src_idle_en = 1'b1;
   bit               sink_idle_en = 1'b1;

   hlat_req_if req_chan ();
   hlat_rsp_if rsp_chan ();

   hit_label_aggregation_table i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   hlat_table_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always #5ns clock = ~clock;

   function automatic logic [LABEL_W-1:0] rand_label();
      return {$urandom, $urandom};
   endfunction

   // mostly real layers, now and then one past the last disk
   function automatic logic [LAYER_W-1:0] rand_layer();
      if ($urandom_range(0, 7) == 0) begin
         return LAYER_W'($urandom_range(10, 15));
      end
      return LAYER_W'($urandom_range(0, 9));
   endfunction

   task automatic send_item(logic op, logic [LABEL_W-1:0] label, logic [LAYER_W-1:0] layer);
      req_chan.valid     <= 1'b1;
      req_chan.op        <= op;
      req_chan.hit_label <= label;
      req_chan.layer     <= layer;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      items_sent++;
      if (src_idle_en && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic add_hit(logic [LABEL_W-1:0] label, logic [LAYER_W-1:0] layer);
      send_item(OP_ADD, label, layer);
   endtask

   // label and layer are don't-care on a drain, so randomize them
   task automatic drain_table();
      send_item(OP_DRAIN, rand_label(), LAYER_W'($urandom_range(0, 15)));
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_disks(logic [MIN_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_phase();
      logic [LABEL_W-1:0] pool [8];
      int                 pool_size;
      int                 n_adds;
      pool_size = $urandom_range(1, 8);
      pool[0]   = rand_label();
      for (int k = 1; k < pool_size; k++) begin
         case ($urandom_range(0, 5))
            0: pool[k] = '0;
            1: pool[k] = '1;
            // one bit away from another label: exercises the full-width compare
            2: pool[k] = pool[0] ^ (LABEL_W'(1) << $urandom_range(0, LABEL_W - 1));
            default: pool[k] = rand_label();
         endcase
      end
      n_adds = $urandom_range(0, 14);
      repeat (n_adds) begin
         if ($urandom_range(0, 9) == 0) begin
            add_hit(rand_label(), rand_layer());
         end else begin
            add_hit(pool[$urandom_range(0, pool_size - 1)], rand_layer());
         end
      end
      drain_table();
      if ($urandom_range(0, 5) == 0) begin
         drain_table();
      end
   endtask

   initial begin : rsp_sink
      int hold;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_len > 0) begin
            hold         = hold_off_len;
            hold_off_len = 0;
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      logic [LABEL_W-1:0] stored_labels [ENTRIES];
      logic [LABEL_W-1:0] sat_label;
      int                 random_end;
      req_chan.valid     <= 1'b0;
      req_chan.op        <= OP_ADD;
      req_chan.hit_label <= '0;
      req_chan.layer     <= '0;
      csr_we             <= 1'b0;
      csr_wdata          <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty drain, label extremes, matches, off-disk layers, all five disks
      drain_table();
      add_hit('0, 4'd0);
      add_hit('1, 4'd9);
      add_hit('0, 4'd2);
      add_hit('0, 4'd15);
      add_hit('1, 4'd10);
      add_hit({1'b1, {(LABEL_W - 2){1'b0}}, 1'b1}, 4'd12);
      add_hit('0, 4'd4);
      add_hit('0, 4'd7);
      add_hit('0, 4'd8);
      add_hit('1, 4'd1);
      add_hit('1, 4'd3);
      add_hit('1, 4'd5);
      drain_table();
      drain_table();

      // minimum of zero: every entry trackable, even with an empty mask
      wait_drained();
      write_min_disks(3'd0);
      add_hit(64'h0123_4567_89ab_cdef, 4'd14);
      add_hit(64'h0123_4567_89ab_cdee, 4'd0);
      drain_table();

      // minimum above the disk count: nothing trackable
      wait_drained();
      write_min_disks(3'd7);
      for (int l = 0; l < 10; l += 2) begin
         add_hit('1, LAYER_W'(l));
      end
      drain_table();

      // count saturation
      wait_drained();
      write_min_disks(3'd5);
      sat_label = rand_label();
      repeat (260) begin
         add_hit(sat_label, rand_layer());
      end
      add_hit(~sat_label, rand_layer());
      drain_table();

      // fill the table, then overflow it; stored labels still count
      wait_drained();
      write_min_disks(3'd2);
      for (int i = 0; i < ENTRIES; i++) begin
         stored_labels[i] = {$urandom, 32'(i)};
         add_hit(stored_labels[i], rand_layer());
      end
      repeat (3) begin
         add_hit(rand_label(), rand_layer());
      end
      repeat (2) begin
         add_hit(stored_labels[$urandom_range(0, ENTRIES - 1)], rand_layer());
      end
      // hold the result side off while the sender keeps pushing
      hold_off_len = HOLD_OFF_CYCLES;
      drain_table();
      for (int i = 0; i < 20; i++) begin
         add_hit(rand_label(), rand_layer());
      end
      drain_table();
      repeat (10) begin
         add_hit(rand_label(), rand_layer());
      end
      drain_table();
      wait_drained();
      drain_table();

      random_end = items_sent + RANDOM_ITEMS;
      while (items_sent < random_end) begin
         if (items_sent > random_end - QUIET_ITEMS) begin
            src_idle_en  = 1'b0;
            sink_idle_en = 1'b0;
         end
         if ($urandom_range(0, 1) == 0) begin
            wait_drained();
            write_min_disks(MIN_W'($urandom_range(0, 7)));
         end
         random_phase();
      end

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: hit_label_aggregation_table.f
+incdir+src
src/hlat_pkg.sv
src/hlat_channels.sv
src/hlat_cell.sv
src/hit_label_aggregation_table.sv
tb/sv/hlat_table_checker.sv
tb/sv/tb_top.sv
